// ===== hdl/priority_schedule_wait_times_defines.svh =====
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_DEFINES_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PSW_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psw check failed");

// next-cycle implication, clocked on clk, off during reset
`define PSW_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psw check failed");

`endif

// ===== hdl/psw_pkg.sv =====
package psw_pkg;

  localparam int DEF_MAX_PROCS = 16;

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 20;
  localparam int AVG_W   = 28;
  localparam int FRAC_W  = 8;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } rec_t;

  // write data source for the record memory
  localparam logic [1:0] WSRC_IN   = 2'd0;
  localparam logic [1:0] WSRC_BEST = 2'd1;
  localparam logic [1:0] WSRC_SLOT = 2'd2;

  typedef struct packed {
    logic       we;
    logic [1:0] wsrc;
    logic       ld_slot;
    logic       upd_best;
    logic       clr_acc;
    logic       acc;
    logic       div_start;
    logic       emit_ld;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic lt;
    logic out_free;
    logic div_done;
  } sts_t;

endpackage

// ===== hdl/psw_div.sv =====
module psw_div #(
  parameter int MAX_PROCS = psw_pkg::DEF_MAX_PROCS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [psw_pkg::BURST_W+2*$clog2(MAX_PROCS+1)+psw_pkg::FRAC_W-1:0] dvd_a,
  input  logic [psw_pkg::BURST_W+2*$clog2(MAX_PROCS+1)+psw_pkg::FRAC_W-1:0] dvd_b,
  input  logic [$clog2(MAX_PROCS+1)-1:0] dvs,
  output logic          done,
  output logic [psw_pkg::BURST_W+2*$clog2(MAX_PROCS+1)+psw_pkg::FRAC_W-1:0] q_a,
  output logic [psw_pkg::BURST_W+2*$clog2(MAX_PROCS+1)+psw_pkg::FRAC_W-1:0] q_b
);

  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int DW  = psw_pkg::BURST_W + 2 * CW + psw_pkg::FRAC_W;
  localparam int RW  = CW + 1;
  localparam int CTW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CTW-1:0] cnt_r;
  logic [DW-1:0] qa_r, qb_r;
  logic [RW-1:0] ra_r, rb_r;
  logic [RW-1:0] ra_sh, rb_sh;
  logic          ba, bb;

  // one quotient bit per cycle, both dividends share the divisor
  always_comb begin
    ra_sh = {ra_r[RW-2:0], qa_r[DW-1]};
    rb_sh = {rb_r[RW-2:0], qb_r[DW-1]};
    ba    = (ra_sh >= {1'b0, dvs});
    bb    = (rb_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CTW'(1);
        if (cnt_r == CTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qa_r <= dvd_a;
      qb_r <= dvd_b;
      ra_r <= '0;
      rb_r <= '0;
    end else if (busy_r) begin
      qa_r <= {qa_r[DW-2:0], ba};
      qb_r <= {qb_r[DW-2:0], bb};
      ra_r <= ba ? (ra_sh - {1'b0, dvs}) : ra_sh;
      rb_r <= bb ? (rb_sh - {1'b0, dvs}) : rb_sh;
    end
  end

  assign done = done_r;
  assign q_a  = qa_r;
  assign q_b  = qb_r;

endmodule

// ===== hdl/psw_datapath.sv =====
module psw_datapath #(
  parameter int MAX_PROCS = psw_pkg::DEF_MAX_PROCS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psw_pkg::cmd_t        cmd,
  output psw_pkg::sts_t        sts,
  input  logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] waddr,
  input  logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] raddr,
  input  logic [$clog2(MAX_PROCS+1)-1:0] n,
  input  logic [psw_pkg::ID_W-1:0]    in_proc_id,
  input  logic [psw_pkg::BURST_W-1:0] in_burst,
  input  logic [psw_pkg::PRIO_W-1:0]  in_prio,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [psw_pkg::ID_W-1:0]    out_id,
  output logic [psw_pkg::BURST_W-1:0] out_burst,
  output logic [psw_pkg::PRIO_W-1:0]  out_prio,
  output logic [psw_pkg::TIME_W-1:0]  out_wait_time,
  output logic [psw_pkg::TIME_W-1:0]  out_turnaround,
  output logic [psw_pkg::AVG_W-1:0]   out_avg_wait_q8,
  output logic [psw_pkg::AVG_W-1:0]   out_avg_turn_q8,
  output logic                        out_last_row
);

  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int EW = psw_pkg::BURST_W + CW;
  localparam int SW = EW + CW;
  localparam int DW = SW + psw_pkg::FRAC_W;

  psw_pkg::rec_t mem_r [MAX_PROCS];
  psw_pkg::rec_t rdata_r;
  psw_pkg::rec_t slot_rec_r;
  psw_pkg::rec_t best_rec_r;
  psw_pkg::rec_t wdata;

  logic [EW-1:0] elapsed_r;
  logic [EW-1:0] elapsed_nxt;
  logic [SW-1:0] wsum_r, tsum_r;
  logic [DW-1:0] q_a, q_b;
  logic          div_done;

  logic                        out_valid_r;
  logic [psw_pkg::ID_W-1:0]    out_id_r;
  logic [psw_pkg::BURST_W-1:0] out_burst_r;
  logic [psw_pkg::PRIO_W-1:0]  out_prio_r;
  logic [psw_pkg::TIME_W-1:0]  out_wait_r, out_turn_r;
  logic [psw_pkg::AVG_W-1:0]   out_avgw_r, out_avgt_r;
  logic                        out_last_r;

  always_comb begin
    case (cmd.wsrc)
      psw_pkg::WSRC_IN:   wdata = '{id: in_proc_id, burst: in_burst, prio: in_prio};
      psw_pkg::WSRC_BEST: wdata = best_rec_r;
      psw_pkg::WSRC_SLOT: wdata = slot_rec_r;
      default:            wdata = best_rec_r;
    endcase
  end

  // record memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  // sort candidates
  always_ff @(posedge clk) begin
    if (cmd.ld_slot) begin
      slot_rec_r <= rdata_r;
      best_rec_r <= rdata_r;
    end else if (cmd.upd_best) begin
      best_rec_r <= rdata_r;
    end
  end

  assign elapsed_nxt = elapsed_r + EW'(rdata_r.burst);

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) begin
      elapsed_r <= '0;
      wsum_r    <= '0;
      tsum_r    <= '0;
    end else if (cmd.acc) begin
      elapsed_r <= elapsed_nxt;
      wsum_r    <= wsum_r + SW'(elapsed_r);
      tsum_r    <= tsum_r + SW'(elapsed_nxt);
    end else if (cmd.emit_ld) begin
      elapsed_r <= elapsed_nxt;
    end
  end

  psw_div #(
    .MAX_PROCS(MAX_PROCS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd_a ({wsum_r, {psw_pkg::FRAC_W{1'b0}}}),
    .dvd_b ({tsum_r, {psw_pkg::FRAC_W{1'b0}}}),
    .dvs   (n),
    .done  (div_done),
    .q_a   (q_a),
    .q_b   (q_b)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_id_r    <= rdata_r.id;
      out_burst_r <= rdata_r.burst;
      out_prio_r  <= rdata_r.prio;
      out_wait_r  <= psw_pkg::TIME_W'(elapsed_r);
      out_turn_r  <= psw_pkg::TIME_W'(elapsed_nxt);
      out_avgw_r  <= psw_pkg::AVG_W'(q_a);
      out_avgt_r  <= psw_pkg::AVG_W'(q_b);
      out_last_r  <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.lt       = (rdata_r.prio < best_rec_r.prio);
    sts.out_free = !out_valid_r || out_ready;
    sts.div_done = div_done;
  end

  assign out_valid       = out_valid_r;
  assign out_id          = out_id_r;
  assign out_burst       = out_burst_r;
  assign out_prio        = out_prio_r;
  assign out_wait_time   = out_wait_r;
  assign out_turnaround  = out_turn_r;
  assign out_avg_wait_q8 = out_avgw_r;
  assign out_avg_turn_q8 = out_avgt_r;
  assign out_last_row    = out_last_r;

endmodule

// ===== hdl/psw_ctrl.sv =====
`include "priority_schedule_wait_times_defines.svh"

module psw_ctrl #(
  parameter int MAX_PROCS = psw_pkg::DEF_MAX_PROCS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_last_proc,
  input  psw_pkg::sts_t sts,
  output psw_pkg::cmd_t cmd,
  output logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] waddr,
  output logic [(MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1)-1:0] raddr,
  output logic [$clog2(MAX_PROCS+1)-1:0] n
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_S_RD   = 4'd1;
  localparam logic [3:0] ST_S_CMP  = 4'd2;
  localparam logic [3:0] ST_S_SW1  = 4'd3;
  localparam logic [3:0] ST_S_SW2  = 4'd4;
  localparam logic [3:0] ST_A_RD   = 4'd5;
  localparam logic [3:0] ST_A_ACC  = 4'd6;
  localparam logic [3:0] ST_D_GO   = 4'd7;
  localparam logic [3:0] ST_D_WAIT = 4'd8;
  localparam logic [3:0] ST_E_RD   = 4'd9;
  localparam logic [3:0] ST_E_LD   = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] best_r, best_nxt;

  logic          full;
  logic [CW-1:0] n_new;
  logic          k_at_end;

  assign full     = (cnt_r == CW'(MAX_PROCS));
  assign n_new    = full ? cnt_r : cnt_r + CW'(1);
  assign k_at_end = (CW'(k_r) == n_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    slot_nxt  = slot_r;
    k_nxt     = k_r;
    best_nxt  = best_r;
    cmd       = '0;
    cmd.wsrc  = psw_pkg::WSRC_IN;
    waddr     = cnt_r[IW-1:0];
    in_ready  = 1'b0;

    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.we = !full;
          if (in_last_proc) begin
            cnt_nxt     = '0;
            n_nxt       = n_new;
            slot_nxt    = '0;
            k_nxt       = '0;
            cmd.clr_acc = 1'b1;
            state_nxt   = (n_new == CW'(1)) ? ST_A_RD : ST_S_RD;
          end else begin
            cnt_nxt = n_new;
          end
        end
      end
      ST_S_RD: begin
        state_nxt = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (k_r == slot_r) begin
          cmd.ld_slot = 1'b1;
          best_nxt    = slot_r;
        end else if (sts.lt) begin
          cmd.upd_best = 1'b1;
          best_nxt     = k_r;
        end
        if (k_at_end) begin
          state_nxt = ST_S_SW1;
        end else begin
          k_nxt     = k_r + IW'(1);
          state_nxt = ST_S_RD;
        end
      end
      ST_S_SW1: begin
        cmd.we    = 1'b1;
        cmd.wsrc  = psw_pkg::WSRC_BEST;
        waddr     = slot_r;
        state_nxt = ST_S_SW2;
      end
      ST_S_SW2: begin
        cmd.we   = 1'b1;
        cmd.wsrc = psw_pkg::WSRC_SLOT;
        waddr    = best_r;
        if (CW'(slot_r) == n_r - CW'(2)) begin
          k_nxt     = '0;
          state_nxt = ST_A_RD;
        end else begin
          slot_nxt  = slot_r + IW'(1);
          k_nxt     = slot_r + IW'(1);
          state_nxt = ST_S_RD;
        end
      end
      ST_A_RD: begin
        state_nxt = ST_A_ACC;
      end
      ST_A_ACC: begin
        cmd.acc = 1'b1;
        if (k_at_end) begin
          k_nxt     = '0;
          state_nxt = ST_D_GO;
        end else begin
          k_nxt     = k_r + IW'(1);
          state_nxt = ST_A_RD;
        end
      end
      ST_D_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_D_WAIT;
      end
      ST_D_WAIT: begin
        if (sts.div_done) begin
          cmd.clr_acc = 1'b1;
          k_nxt       = '0;
          state_nxt   = ST_E_RD;
        end
      end
      ST_E_RD: begin
        state_nxt = ST_E_LD;
      end
      ST_E_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld   = 1'b1;
          cmd.emit_last = k_at_end;
          if (k_at_end) begin
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = ST_E_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      slot_r  <= '0;
      k_r     <= '0;
      best_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      slot_r  <= slot_nxt;
      k_r     <= k_nxt;
      best_r  <= best_nxt;
    end
  end

  assign raddr = k_r;
  assign n     = n_r;

  // a schedule always holds at least one record
  `PSW_AST_NXT(a_start_nonempty, in_valid && in_ready && in_last_proc,
               state_r != ST_LOAD && n_r != '0)
  // scan index stays inside the batch and never behind the slot
  `PSW_AST_IMP(a_scan_range, state_r == ST_S_CMP, CW'(k_r) < n_r && slot_r <= k_r)
  // emission follows the divider
  `PSW_AST_NXT(a_div_to_emit, state_r == ST_D_WAIT && sts.div_done, state_r == ST_E_RD)
  // a row is never loaded over one still pending
  `PSW_AST_IMP(a_no_overwrite, cmd.emit_ld, sts.out_free)

endmodule

// ===== hdl/priority_schedule_wait_times.sv =====
// Non-preemptive priority scheduler. Records (id, burst, priority) are taken one per cycle
// into a record memory (one write, one read port); the record flagged last_proc starts
// the schedule, and records beyond MAX_PROCS are dropped. The batch is selection sorted on
// priority (lowest first, first strict minimum wins, swap), then one row per record is
// emitted with wait time, turnaround and the batch averages in unsigned Q.8. Each sort
// compare reads a record through the registered memory read, each swap writes both
// records in turn, the times are summed by a read and an accumulate per record, a
// bit-serial divider yields 16 + 2*clog2(MAX_PROCS+1) + 8 quotient bits, and a row waits
// while the output is stalled. New records are not taken until the last row is registered.
module priority_schedule_wait_times #(
  parameter int MAX_PROCS = psw_pkg::DEF_MAX_PROCS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [psw_pkg::ID_W-1:0]    in_proc_id,
  input  logic [psw_pkg::BURST_W-1:0] in_burst,
  input  logic [psw_pkg::PRIO_W-1:0]  in_prio,
  input  logic                        in_last_proc,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [psw_pkg::ID_W-1:0]    out_id,
  output logic [psw_pkg::BURST_W-1:0] out_burst,
  output logic [psw_pkg::PRIO_W-1:0]  out_prio,
  output logic [psw_pkg::TIME_W-1:0]  out_wait_time,
  output logic [psw_pkg::TIME_W-1:0]  out_turnaround,
  output logic [psw_pkg::AVG_W-1:0]   out_avg_wait_q8,
  output logic [psw_pkg::AVG_W-1:0]   out_avg_turn_q8,
  output logic                        out_last_row
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  psw_pkg::cmd_t cmd;
  psw_pkg::sts_t sts;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  logic [CW-1:0] n;

  psw_ctrl #(
    .MAX_PROCS(MAX_PROCS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_last_proc (in_last_proc),
    .sts          (sts),
    .cmd          (cmd),
    .waddr        (waddr),
    .raddr        (raddr),
    .n            (n)
  );

  psw_datapath #(
    .MAX_PROCS(MAX_PROCS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .waddr           (waddr),
    .raddr           (raddr),
    .n               (n),
    .in_proc_id      (in_proc_id),
    .in_burst        (in_burst),
    .in_prio         (in_prio),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_id          (out_id),
    .out_burst       (out_burst),
    .out_prio        (out_prio),
    .out_wait_time   (out_wait_time),
    .out_turnaround  (out_turnaround),
    .out_avg_wait_q8 (out_avg_wait_q8),
    .out_avg_turn_q8 (out_avg_turn_q8),
    .out_last_row    (out_last_row)
  );

endmodule
